>>> hdl/fpfm_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the control program of the page-frame manager.
package fpfm_pkg;

    localparam int FRAMES  = 8;
    localparam int FIDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int FRAME_W = 6;

    localparam int IDX_W   = 32;
    localparam int PS_W    = 17;
    localparam int OFF_W   = 16;
    localparam int CNT_W   = 32;

    localparam logic [PS_W-1:0] PAGE_SIZE_RESET = PS_W'(1024);
    localparam logic [PS_W-1:0] PAGE_SIZE_MAX   = PS_W'(65536);

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [1:0] KIND_ACCESS = 2'd0;
    localparam logic [1:0] KIND_WB     = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;

    typedef enum logic [2:0] {
        ACT_ACCEPT,
        ACT_NONE,
        ACT_DIV_START,
        ACT_DIV_WAIT,
        ACT_EMIT_ACC,
        ACT_FL_INIT,
        ACT_EMIT_WB,
        ACT_FL_NEXT
    } t_act;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_IS_FLUSH,
        COND_IS_NOP,
        COND_CLEAN,
        COND_MORE
    } t_cond;

    localparam int STEP_W = 4;

    localparam logic [STEP_W-1:0] STEP_IDLE     = 4'd0;
    localparam logic [STEP_W-1:0] STEP_BR_FLUSH = 4'd1;
    localparam logic [STEP_W-1:0] STEP_BR_NOP   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_DIV      = 4'd3;
    localparam logic [STEP_W-1:0] STEP_DIV_WAIT = 4'd4;
    localparam logic [STEP_W-1:0] STEP_LOOKUP   = 4'd5;
    localparam logic [STEP_W-1:0] STEP_FL_INIT  = 4'd6;
    localparam logic [STEP_W-1:0] STEP_FL_TEST  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_FL_WB    = 4'd8;
    localparam logic [STEP_W-1:0] STEP_FL_NEXT  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_FL_DONE  = 4'd10;

    typedef struct packed {
        t_act              act;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [FRAME_W-1:0] frame;
        logic [OFF_W-1:0]   word_offset;
        logic [IDX_W-1:0]   page_number;
        logic               hit;
        logic               fill_needed;
        logic               writeback_needed;
        logic [IDX_W-1:0]   victim_page;
        logic               last;
        logic [CNT_W-1:0]   hit_count;
        logic [CNT_W-1:0]   fault_count;
    } t_result;

    // Control store: a conditional jump goes to target, otherwise to the next step.
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        case (step)
            STEP_IDLE:     w = '{ACT_ACCEPT,    COND_NEVER,    STEP_IDLE};
            STEP_BR_FLUSH: w = '{ACT_NONE,      COND_IS_FLUSH, STEP_FL_INIT};
            STEP_BR_NOP:   w = '{ACT_NONE,      COND_IS_NOP,   STEP_IDLE};
            STEP_DIV:      w = '{ACT_DIV_START, COND_NEVER,    STEP_IDLE};
            STEP_DIV_WAIT: w = '{ACT_DIV_WAIT,  COND_NEVER,    STEP_IDLE};
            STEP_LOOKUP:   w = '{ACT_EMIT_ACC,  COND_ALWAYS,   STEP_IDLE};
            STEP_FL_INIT:  w = '{ACT_FL_INIT,   COND_NEVER,    STEP_IDLE};
            STEP_FL_TEST:  w = '{ACT_NONE,      COND_CLEAN,    STEP_FL_NEXT};
            STEP_FL_WB:    w = '{ACT_EMIT_WB,   COND_NEVER,    STEP_IDLE};
            STEP_FL_NEXT:  w = '{ACT_FL_NEXT,   COND_MORE,     STEP_FL_TEST};
            STEP_FL_DONE:  w = '{ACT_NONE,      COND_ALWAYS,   STEP_IDLE};
            default:       w = '{ACT_NONE,      COND_ALWAYS,   STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> hdl/fpfm_in_if.sv
`timescale 1ns / 1ps
// Command channel: one access or flush word per handshake.
interface fpfm_in_if import fpfm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       command;
    logic [IDX_W-1:0] element_index;

    modport source (output valid, output command, output element_index, input ready);
    modport sink   (input valid, input command, input element_index, output ready);
endinterface

>>> hdl/fpfm_out_if.sv
`timescale 1ns / 1ps
// Result channel: one access, writeback or done word per handshake.
interface fpfm_out_if import fpfm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         result_kind;
    logic [FRAME_W-1:0] frame;
    logic [OFF_W-1:0]   word_offset;
    logic [IDX_W-1:0]   page_number;
    logic               hit;
    logic               fill_needed;
    logic               writeback_needed;
    logic [IDX_W-1:0]   victim_page;
    logic               last;
    logic [CNT_W-1:0]   hit_count;
    logic [CNT_W-1:0]   fault_count;

    modport source (
        output valid, output result_kind, output frame, output word_offset,
        output page_number, output hit, output fill_needed, output writeback_needed,
        output victim_page, output last, output hit_count, output fault_count,
        input ready
    );
    modport sink (
        input valid, input result_kind, input frame, input word_offset,
        input page_number, input hit, input fill_needed, input writeback_needed,
        input victim_page, input last, input hit_count, input fault_count,
        output ready
    );
endinterface

>>> hdl/fpfm_div.sv
`timescale 1ns / 1ps
// Restoring divider: one quotient bit per cycle, splits an index into page and offset.
module fpfm_div import fpfm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [IDX_W-1:0] i_dividend,
    input  logic [PS_W-1:0]  i_divisor,
    output logic             o_busy,
    output logic [IDX_W-1:0] o_quot,
    output logic [OFF_W-1:0] o_rem
);

    localparam int ITER_W = $clog2(IDX_W + 1);

    logic [ITER_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0]  r_quot, n_quot;
    logic [PS_W-1:0]   r_rem, n_rem;
    logic [PS_W-1:0]   r_div, n_div;
    logic [PS_W:0]     shifted;
    logic [PS_W:0]     diff;

    always_comb begin
        shifted = {r_rem, r_quot[IDX_W-1]};
        diff    = shifted - {1'b0, r_div};
        n_cnt   = r_cnt;
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_div   = r_div;
        if (i_start) begin
            n_cnt  = ITER_W'(IDX_W);
            n_quot = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - ITER_W'(1);
            // The remainder stays below the divisor, so it always fits back.
            if (shifted >= {1'b0, r_div}) begin
                n_rem  = diff[PS_W-1:0];
                n_quot = {r_quot[IDX_W-2:0], 1'b1};
            end else begin
                n_rem  = shifted[PS_W-1:0];
                n_quot = {r_quot[IDX_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_div  <= n_div;
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quot;
    assign o_rem  = r_rem[OFF_W-1:0];

endmodule

>>> hdl/fifo_page_frame_manager_unit.sv
`timescale 1ns / 1ps
// Page-frame manager top level: microcoded sequencer, frame table and result register.
//
// This block manages eight frames of a fully associative page cache with round-robin
// replacement. Each command word is a read access, a write access or a flush. An access
// splits the element index into page number and word offset by the configured page size
// (zero counts as one, values above 65536 as 65536), looks the page up in all frames at
// once and produces one result word: on a miss it claims the lowest empty frame or else
// the round-robin victim, and flags a writeback with the old page when that victim is
// dirty. A write marks the frame dirty. A flush produces one writeback word per dirty
// frame in ascending frame order, clears the dirty marks and closes with a done word.
// Hit and fault counters saturate and every result word carries their current values.
// An access passes from acceptance through three steps of command decode and divider
// start, the wait in the bit-serial divider (one quotient bit per cycle over the 32-bit
// index) and one lookup step. A flush clears its scan index, tests each frame in turn and
// writes back the dirty ones before its done word. The command channel takes a new
// word only while the sequencer sits in its idle step; the result register lets one
// finished word wait for the sink, and the sequencer holds only when a second word is
// ready before the first was taken. The page size register may be written only while
// the block is idle; the unused command code three is dropped without any result.
module fifo_page_frame_manager_unit import fpfm_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [PS_W-1:0] i_cfg_page_size,
    fpfm_in_if.sink         i_cmd,
    fpfm_out_if.source      o_res
);

    // Sequencer state.
    logic [STEP_W-1:0] r_step, n_step;
    t_uword            uw;
    logic              stall;
    logic              cond_true;

    // Accepted command.
    logic [1:0]        r_cmd;
    logic [IDX_W-1:0]  r_index;

    // Configuration.
    logic [PS_W-1:0]   r_page_size;
    logic [PS_W-1:0]   ps_eff;

    // Frame table. Page tags have no reset; they are only read behind a valid bit.
    logic [FRAMES-1:0] r_valid;
    logic [FRAMES-1:0] r_dirty;
    logic [IDX_W-1:0]  r_frame_page [FRAMES];
    logic [FIDX_W-1:0] r_victim;
    logic [FIDX_W-1:0] r_scan;
    logic [CNT_W-1:0]  r_hits, r_faults;
    logic [CNT_W-1:0]  hits_inc, faults_inc;

    // Divider.
    logic              div_busy;
    logic [IDX_W-1:0]  div_quot;
    logic [OFF_W-1:0]  div_rem;

    // Lookup.
    logic              hit_found, free_found;
    logic [FIDX_W-1:0] hit_idx, free_idx, sel_frame, victim_next;
    logic              wb_needed;
    logic [FIDX_W-1:0] rd_addr;
    logic [IDX_W-1:0]  rd_page;
    logic              new_dirty;

    // Result register.
    logic              r_out_valid;
    t_result           r_out;
    logic              out_free;
    logic              emit;

    fpfm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (uw.act == ACT_DIV_START),
        .i_dividend (r_index),
        .i_divisor  (ps_eff),
        .o_busy     (div_busy),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign uw       = ucode(r_step);
    assign out_free = !r_out_valid || o_res.ready;
    assign ps_eff   = (r_page_size == '0)           ? PS_W'(1) :
                      (r_page_size > PAGE_SIZE_MAX) ? PAGE_SIZE_MAX : r_page_size;

    // A step holds while its handshake or the divider is not ready.
    always_comb begin
        case (uw.act)
            ACT_ACCEPT:   stall = !i_cmd.valid;
            ACT_DIV_WAIT: stall = div_busy;
            ACT_EMIT_ACC: stall = !out_free;
            ACT_EMIT_WB:  stall = !out_free;
            default:      stall = 1'b0;
        endcase
        // The done word goes out from its own step once the result register frees up.
        if (r_step == STEP_FL_DONE) begin
            stall = !out_free;
        end
    end

    always_comb begin
        case (uw.cond)
            COND_NEVER:    cond_true = 1'b0;
            COND_ALWAYS:   cond_true = 1'b1;
            COND_IS_FLUSH: cond_true = (r_cmd == CMD_FLUSH);
            COND_IS_NOP:   cond_true = (r_cmd == CMD_NOP);
            COND_CLEAN:    cond_true = !(r_valid[r_scan] && r_dirty[r_scan]);
            COND_MORE:     cond_true = (r_scan != FIDX_W'(FRAMES - 1));
            default:       cond_true = 1'b0;
        endcase
    end

    always_comb begin
        if (stall) begin
            n_step = r_step;
        end else if (cond_true) begin
            n_step = uw.target;
        end else begin
            n_step = r_step + STEP_W'(1);
        end
    end

    assign i_cmd.ready = (uw.act == ACT_ACCEPT);

    // Associative lookup across all frames; lowest matching and lowest empty frame win.
    always_comb begin
        hit_found  = 1'b0;
        hit_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_frame_page[i] == div_quot)) begin
                hit_found = 1'b1;
                hit_idx   = FIDX_W'(i);
            end
            if (!r_valid[i]) begin
                free_found = 1'b1;
                free_idx   = FIDX_W'(i);
            end
        end
    end

    assign sel_frame   = hit_found ? hit_idx : (free_found ? free_idx : r_victim);
    assign wb_needed   = !hit_found && !free_found && r_dirty[r_victim];
    assign victim_next = (r_victim == FIDX_W'(FRAMES - 1)) ? '0 : r_victim + FIDX_W'(1);
    assign new_dirty   = (r_cmd == CMD_WRITE) || (hit_found && r_dirty[sel_frame]);

    // One read port on the tag store serves both the victim and the flush scan.
    assign rd_addr = (uw.act == ACT_EMIT_ACC) ? r_victim : r_scan;
    assign rd_page = r_frame_page[rd_addr];

    assign hits_inc   = (r_hits == '1)   ? r_hits   : r_hits + CNT_W'(1);
    assign faults_inc = (r_faults == '1) ? r_faults : r_faults + CNT_W'(1);

    assign emit = !stall && ((uw.act == ACT_EMIT_ACC) || (uw.act == ACT_EMIT_WB) ||
                             (r_step == STEP_FL_DONE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_IDLE;
            r_page_size <= PAGE_SIZE_RESET;
            r_valid     <= '0;
            r_dirty     <= '0;
            r_victim    <= '0;
            r_scan      <= '0;
            r_hits      <= '0;
            r_faults    <= '0;
            r_cmd       <= CMD_READ;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;

            if (i_cfg_we) begin
                r_page_size <= i_cfg_page_size;
            end

            if ((uw.act == ACT_ACCEPT) && i_cmd.valid) begin
                r_cmd <= i_cmd.command;
            end

            if (!stall) begin
                case (uw.act)
                    ACT_EMIT_ACC: begin
                        r_dirty[sel_frame] <= new_dirty;
                        if (hit_found) begin
                            r_hits <= hits_inc;
                        end else begin
                            r_valid[sel_frame] <= 1'b1;
                            r_faults           <= faults_inc;
                            if (!free_found) begin
                                r_victim <= victim_next;
                            end
                        end
                    end
                    ACT_FL_INIT: r_scan <= '0;
                    ACT_EMIT_WB: r_dirty[r_scan] <= 1'b0;
                    ACT_FL_NEXT: r_scan <= r_scan + FIDX_W'(1);
                    default: ;
                endcase
            end

            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if ((uw.act == ACT_ACCEPT) && i_cmd.valid) begin
            r_index <= i_cmd.element_index;
        end

        if (!stall && (uw.act == ACT_EMIT_ACC) && !hit_found) begin
            r_frame_page[sel_frame] <= div_quot;
        end

        if (emit) begin
            if (uw.act == ACT_EMIT_ACC) begin
                r_out.result_kind      <= KIND_ACCESS;
                r_out.frame            <= FRAME_W'(sel_frame);
                r_out.word_offset      <= div_rem;
                r_out.page_number      <= div_quot;
                r_out.hit              <= hit_found;
                r_out.fill_needed      <= !hit_found;
                r_out.writeback_needed <= wb_needed;
                r_out.victim_page      <= wb_needed ? rd_page : '0;
                r_out.last             <= 1'b1;
                r_out.hit_count        <= hit_found ? hits_inc : r_hits;
                r_out.fault_count      <= hit_found ? r_faults : faults_inc;
            end else if (uw.act == ACT_EMIT_WB) begin
                r_out.result_kind      <= KIND_WB;
                r_out.frame            <= FRAME_W'(r_scan);
                r_out.word_offset      <= '0;
                r_out.page_number      <= rd_page;
                r_out.hit              <= 1'b0;
                r_out.fill_needed      <= 1'b0;
                r_out.writeback_needed <= 1'b0;
                r_out.victim_page      <= '0;
                r_out.last             <= 1'b0;
                r_out.hit_count        <= r_hits;
                r_out.fault_count      <= r_faults;
            end else begin
                r_out.result_kind      <= KIND_DONE;
                r_out.frame            <= '0;
                r_out.word_offset      <= '0;
                r_out.page_number      <= '0;
                r_out.hit              <= 1'b0;
                r_out.fill_needed      <= 1'b0;
                r_out.writeback_needed <= 1'b0;
                r_out.victim_page      <= '0;
                r_out.last             <= 1'b1;
                r_out.hit_count        <= r_hits;
                r_out.fault_count      <= r_faults;
            end
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.result_kind      = r_out.result_kind;
    assign o_res.frame            = r_out.frame;
    assign o_res.word_offset      = r_out.word_offset;
    assign o_res.page_number      = r_out.page_number;
    assign o_res.hit              = r_out.hit;
    assign o_res.fill_needed      = r_out.fill_needed;
    assign o_res.writeback_needed = r_out.writeback_needed;
    assign o_res.victim_page      = r_out.victim_page;
    assign o_res.last             = r_out.last;
    assign o_res.hit_count        = r_out.hit_count;
    assign o_res.fault_count      = r_out.fault_count;

endmodule
